// ===== sv/bcr_pkg.sv =====
// Shared types, constants and microcode table for the bicubic Catmull-Rom interpolator.
package bcr_pkg;

    localparam int ROW_BITS = 24;
    localparam int ROW_FRAC = 6;
    localparam int PC_BITS  = 3;

    localparam logic [2:0] OP_A0    = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_A1    = 3'd2;
    localparam logic [2:0] OP_A2    = 3'd3;
    localparam logic [2:0] OP_SUM   = 3'd4;
    localparam logic [2:0] OP_STORE = 3'd5;

    localparam logic BR_NEXT = 1'b0;
    localparam logic BR_FORK = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic       br;
    } ucode_t;

    typedef struct packed {
        logic       busy;
        logic       col;
        logic [2:0] op;
    } seq_ctl_t;

    typedef struct packed {
        logic start;
        logic stall;
        logic row_last;
    } seq_stat_t;

    // Horner program: one cubic pass, forked at the end into the column pass or idle
    function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
        ucode_t w;
        case (pc)
            3'd0:    w = '{op: OP_A0,    br: BR_NEXT};
            3'd1:    w = '{op: OP_MUL,   br: BR_NEXT};
            3'd2:    w = '{op: OP_A1,    br: BR_NEXT};
            3'd3:    w = '{op: OP_MUL,   br: BR_NEXT};
            3'd4:    w = '{op: OP_A2,    br: BR_NEXT};
            3'd5:    w = '{op: OP_MUL,   br: BR_NEXT};
            3'd6:    w = '{op: OP_SUM,   br: BR_NEXT};
            3'd7:    w = '{op: OP_STORE, br: BR_FORK};
            default: w = '{op: OP_STORE, br: BR_FORK};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/bcr_seq.sv =====
// Microcode sequencer: step counter, control ROM and pass fork.
module bcr_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  bcr_pkg::seq_stat_t  stat,
    output bcr_pkg::seq_ctl_t   ctl
);

    logic [bcr_pkg::PC_BITS-1:0] pc_reg, pc_next;
    logic                        busy_reg, busy_next;
    logic                        col_reg, col_next;
    bcr_pkg::ucode_t             uw;

    assign uw = bcr_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        col_next  = col_reg;
        if (stat.start)
        begin
            pc_next   = '0;
            busy_next = 1'b1;
            col_next  = 1'b0;
        end
        else if (busy_reg && !stat.stall)
        begin
            if (uw.br == bcr_pkg::BR_FORK)
            begin
                pc_next = '0;
                if (!col_reg && stat.row_last)
                begin
                    col_next = 1'b1;
                end
                else
                begin
                    busy_next = 1'b0;
                    col_next  = 1'b0;
                end
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
            col_reg  <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    assign ctl.busy = busy_reg;
    assign ctl.col  = col_reg;
    assign ctl.op   = uw.op;

endmodule

// ===== sv/bicubic_catmull_rom_interp.sv =====
// Top level: bicubic Catmull-Rom interpolator, one row of a 4x4 patch per input item.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: sample_a..sample_d, frac_x, frac_y
//  m_*      out  m_tvalid/m_tready  tdata: pixel_out; tuser: saturated
//
// Each row takes the accepting cycle, then 8 microcode steps on one shared multiplier
// (three dependent products per cubic); the fourth row adds an 8-step pass down the stored
// row results.
// Input is taken only while the sequencer is idle; the result register frees the output side.
// A full result register stalls the final store step until it is taken.
// Reset clears the row count, sequencer and output valid; row store needs no clearing.
module bicubic_catmull_rom_interp #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // sample_a, sample_b, sample_c, sample_d, frac_x, frac_y, zero fill
    input  logic [((4*SAMPLE_BITS+2*FRAC_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // pixel_out, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]              m_tdata,
    // saturated
    output logic [0:0]                                    m_tuser
);

    localparam int OUT_W = ((SAMPLE_BITS+7)/8)*8;
    localparam int PW    = (SAMPLE_BITS + bcr_pkg::ROW_FRAC > bcr_pkg::ROW_BITS) ?
                           SAMPLE_BITS + bcr_pkg::ROW_FRAC : bcr_pkg::ROW_BITS;
    localparam int AW    = PW + 5;
    localparam int MW    = AW + FRAC_BITS + 1;
    localparam int SW    = MW + 1;

    localparam logic signed [SW-1:0] R_HI = (SW'(1) <<< (bcr_pkg::ROW_BITS-1)) - SW'(1);
    localparam logic signed [SW-1:0] R_LO = ~R_HI;
    localparam logic signed [SW-1:0] S_HI = (SW'(1) <<< (SAMPLE_BITS-1)) - SW'(1);
    localparam logic signed [SW-1:0] S_LO = ~S_HI;

    bcr_pkg::seq_ctl_t  ctl;
    bcr_pkg::seq_stat_t stat;

    logic signed [SAMPLE_BITS-1:0]          samp_reg [4];
    logic [FRAC_BITS-1:0]                   fx_reg, fy_reg;
    logic signed [bcr_pkg::ROW_BITS-1:0]    rr_reg [4];
    logic [1:0]                             row_cnt_reg, row_cnt_next;
    logic                                   row_clip_reg, row_clip_next;
    logic signed [AW-1:0]                   acc_reg, acc_next;
    logic signed [MW-1:0]                   prod_reg, prod_next;
    logic signed [SW-1:0]                   vsum_reg, vsum_next;
    logic signed [SAMPLE_BITS-1:0]          pix_reg, pix_next;
    logic                                   sat_reg, sat_next;
    logic                                   out_valid_reg, out_valid_next;

    logic signed [AW-1:0]        e [4];
    logic signed [AW-1:0]        d12, t_a0, t_b, t_c, sh;
    logic signed [FRAC_BITS:0]   xs;
    logic signed [SW-1:0]        rnd, q, hi, lo, clipped;
    logic                        hit, accept, step, store_row, store_col;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !ctl.busy;

    assign stat.start    = accept;
    assign stat.row_last = (row_cnt_reg == 2'd3);
    assign stat.stall    = ctl.busy && (ctl.op == bcr_pkg::OP_STORE) && ctl.col &&
                           out_valid_reg && !m_tready;

    bcr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    assign step = ctl.busy && !stat.stall;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            e[i] = ctl.col ? AW'(rr_reg[i]) : (AW'(samp_reg[i]) <<< bcr_pkg::ROW_FRAC);
        end
    end

    assign d12  = e[1] - e[2];
    assign t_a0 = (d12 <<< 1) + d12 + e[3] - e[0];
    assign t_b  = (e[0] <<< 1) - (e[1] <<< 2) - e[1] + (e[2] <<< 2) - e[3];
    assign t_c  = e[2] - e[0];
    assign xs   = $signed({1'b0, (ctl.col ? fy_reg : fx_reg)});
    assign sh   = $signed(prod_reg[FRAC_BITS +: AW]);
    assign rnd  = ctl.col ? (SW'(1) <<< (FRAC_BITS + bcr_pkg::ROW_FRAC)) :
                            (SW'(1) <<< FRAC_BITS);
    assign q    = ctl.col ? (vsum_reg >>> (FRAC_BITS + 1 + bcr_pkg::ROW_FRAC)) :
                            (vsum_reg >>> (FRAC_BITS + 1));
    assign hi   = ctl.col ? S_HI : R_HI;
    assign lo   = ctl.col ? S_LO : R_LO;
    assign hit  = (q > hi) || (q < lo);
    assign clipped = (q > hi) ? hi : ((q < lo) ? lo : q);

    assign store_row = step && (ctl.op == bcr_pkg::OP_STORE) && !ctl.col;
    assign store_col = step && (ctl.op == bcr_pkg::OP_STORE) && ctl.col;

    always_comb
    begin
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        vsum_next      = vsum_reg;
        row_cnt_next   = row_cnt_reg;
        row_clip_next  = row_clip_reg;
        pix_next       = pix_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (step)
        begin
            case (ctl.op)
                bcr_pkg::OP_A0:  acc_next  = t_a0;
                bcr_pkg::OP_MUL: prod_next = acc_reg * xs;
                bcr_pkg::OP_A1:  acc_next  = sh + t_b;
                bcr_pkg::OP_A2:  acc_next  = sh + t_c;
                bcr_pkg::OP_SUM: vsum_next = SW'(prod_reg) + (SW'(e[1]) <<< (FRAC_BITS + 1)) + rnd;
                bcr_pkg::OP_STORE:
                begin
                    if (ctl.col)
                    begin
                        pix_next       = clipped[SAMPLE_BITS-1:0];
                        sat_next       = hit || row_clip_reg;
                        row_clip_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        row_cnt_next  = row_cnt_reg + 2'd1;
                        row_clip_next = row_clip_reg || hit;
                    end
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            row_clip_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_cnt_reg   <= row_cnt_next;
            row_clip_reg  <= row_clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        vsum_reg <= vsum_next;
        pix_reg  <= pix_next;
        sat_reg  <= sat_next;
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                samp_reg[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
            fx_reg <= s_tdata[4*SAMPLE_BITS +: FRAC_BITS];
            fy_reg <= s_tdata[4*SAMPLE_BITS+FRAC_BITS +: FRAC_BITS];
        end
        if (store_row)
        begin
            rr_reg[row_cnt_reg] <= clipped[bcr_pkg::ROW_BITS-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'($unsigned(pix_reg));
    assign m_tuser  = sat_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken while a row is still in work");

    a_col_pass_at_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.busy && ctl.col) |-> (row_cnt_reg == 2'd0))
        else $error("column pass running with rows outstanding");

    a_result_clears_clip: assert property (@(posedge clk) disable iff (!rst_n)
        store_col |=> (!row_clip_reg && m_tvalid))
        else $error("row clip flag kept past its result");

    a_store_col_room: assert property (@(posedge clk) disable iff (!rst_n)
        store_col |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

endmodule
